FILE: hw/rtl/minimum_spanning_tree_weight_defines.svh
// assertion macros shared by the minimum spanning tree weight rtl
// depends on nothing; users provide clk and rst_n in scope
`ifndef MINIMUM_SPANNING_TREE_WEIGHT_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_WEIGHT_DEFINES_SVH

// same-cycle implication
`define MSTW_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mstw_pkg.sv
// package for the minimum spanning tree weight block: beat types, edge record
// and default sizes; depends on nothing
package mstw_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;
    localparam int VERT_W        = 11;
    localparam int WEIGHT_W      = 32;
    localparam int SUM_W         = 64;
    localparam int TREE_EDGES_W  = 10;

    typedef struct packed {
        logic [VERT_W-1:0]          end_a;
        logic [VERT_W-1:0]          end_b;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last_edge;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]    total_weight;
        logic [TREE_EDGES_W-1:0]    tree_edges;
        logic                       overflow;
    } out_item_t;

    typedef struct packed {
        logic [VERT_W-1:0]          a;
        logic [VERT_W-1:0]          b;
        logic signed [WEIGHT_W-1:0] w;
    } edge_t;

endpackage

FILE: hw/rtl/minimum_spanning_tree_weight.sv
// Minimum spanning tree weight. Edges are taken one beat per cycle into an
// edge memory until the beat marked last_edge; the block then drops in_ready,
// sorts the stored edges with a merge sort on the ping-pong edge memories,
// clears the union-find entries of the clamped node count (one per cycle),
// and walks the sorted edges: each edge is read, each end is found by
// following parents to the root and then compressing the path, and a join
// links the two roots by rank. The result beat then waits in an output
// register while loading of the next graph goes on.
// top level; depends on mstw_pkg, mstw_sort, mstw_uf and the defines header
`include "minimum_spanning_tree_weight_defines.svh"

module minimum_spanning_tree_weight
    import mstw_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [VERT_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES+1);
    localparam int NW  = $clog2(MAX_NODES+1);
    localparam int TW  = $clog2(MAX_NODES);

    localparam logic [1:0] T_LOAD = 2'd0;
    localparam logic [1:0] T_SORT = 2'd1;
    localparam logic [1:0] T_WALK = 2'd2;
    localparam logic [1:0] T_HOLD = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [VERT_W-1:0] node_count_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              accept, room, ld_en, sort_start, sort_done, uf_done, slot_free;
    logic [CW-1:0]     sort_cnt;
    logic [NW-1:0]     n_eff;
    edge_t             ld_data, rd_data;
    logic [EAW-1:0]    rd_addr;
    logic [SUM_W-1:0]  uf_sum;
    logic [TW-1:0]     uf_taken;

    assign in_ready  = (state_reg == T_LOAD);
    assign accept    = in_valid && in_ready;
    assign room      = fill_reg < CW'(MAX_EDGES);
    assign ld_en     = accept && room;
    assign ld_data   = '{a: in_item.end_a, b: in_item.end_b, w: in_item.weight};
    assign sort_start = accept && in_item.last_edge;
    assign sort_cnt  = room ? fill_reg + CW'(1) : fill_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // vertex count clamped to the table size
    assign n_eff = (32'(node_count_reg) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count_reg);

    mstw_sort #(
        .MAX_EDGES (MAX_EDGES)
    ) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld_en   (ld_en),
        .ld_addr (fill_reg[EAW-1:0]),
        .ld_data (ld_data),
        .start   (sort_start),
        .cnt     (sort_cnt),
        .done    (sort_done),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mstw_uf #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_uf (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_done),
        .n_eff   (n_eff),
        .cnt     (fill_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (uf_done),
        .sum     (uf_sum),
        .taken   (uf_taken)
    );

    // load, sort, walk and result sequencing
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        case (state_reg)
            T_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_item.last_edge)
                    begin
                        state_next = T_SORT;
                    end
                end
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    state_next = T_WALK;
                end
            end
            T_WALK, T_HOLD:
            begin
                if (uf_done || state_reg == T_HOLD)
                begin
                    if (slot_free)
                    begin
                        out_valid_next             = 1'b1;
                        out_item_next.total_weight = uf_sum;
                        out_item_next.tree_edges   = TREE_EDGES_W'(uf_taken);
                        out_item_next.overflow     = ovf_reg;
                        fill_next                  = '0;
                        ovf_next                   = 1'b0;
                        state_next                 = T_LOAD;
                    end
                    else
                    begin
                        state_next = T_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    // control state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_LOAD;
            node_count_reg <= VERT_W'(1);
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    `MSTW_ASSERT_NEXT(a_last_blocks_input, sort_start, !in_ready, "input open after last edge")
    `MSTW_ASSERT(a_fill_bound, 1'b1, fill_reg <= CW'(MAX_EDGES), "edge count beyond store")
    `MSTW_ASSERT(a_sort_done_state, sort_done, state_reg == T_SORT, "sort done outside sort")
    `MSTW_ASSERT(a_walk_done_state, uf_done, state_reg == T_WALK, "walk done outside walk")

endmodule

FILE: hw/rtl/mstw_sort.sv
// edge store and stable bottom-up merge sort over two ping-pong memories
// depends on mstw_pkg
module mstw_sort
    import mstw_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ld_en,
    input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] ld_addr,
    input  edge_t                                 ld_data,
    input  logic                                  start,
    input  logic [$clog2(MAX_EDGES+1)-1:0]        cnt,
    output logic                                  done,
    input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
    output edge_t                                 rd_data
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES+1);
    localparam int XW  = CW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_BLK  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;

    edge_t mem_a [MAX_EDGES];
    edge_t mem_b [MAX_EDGES];

    logic [2:0]    state_reg, state_next;
    logic          src_reg, src_next;
    logic [XW-1:0] width_reg, width_next;
    logic [XW-1:0] lo_reg, lo_next;
    logic [XW-1:0] mid_reg, mid_next;
    logic [XW-1:0] hi_reg, hi_next;
    logic [XW-1:0] i_reg, i_next;
    logic [XW-1:0] j_reg, j_next;
    logic [XW-1:0] k_reg, k_next;
    logic [XW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic [EAW-1:0] addr0, addr1, wa_addr, wb_addr;
    logic           wa_en, wb_en;
    edge_t          wa_data, wb_data, w_data;
    edge_t          rd_a0, rd_a1, rd_b0, rd_b1, d_i, d_j;
    logic           take_j;
    logic [XW-1:0]  sum_w, sum_2w;

    // read addresses: merge reads during a pass, walk reads otherwise
    assign addr0 = (state_reg == S_RD) ? i_reg[EAW-1:0] : rd_addr;
    assign addr1 = j_reg[EAW-1:0];

    assign d_i     = src_reg ? rd_b0 : rd_a0;
    assign d_j     = src_reg ? rd_b1 : rd_a1;
    assign rd_data = src_reg ? rd_b0 : rd_a0;
    assign done    = done_reg;

    // merge compare, earlier run wins ties
    assign take_j = (j_reg < hi_reg) && ((i_reg >= mid_reg) || ($signed(d_j.w) < $signed(d_i.w)));
    assign w_data = take_j ? d_j : d_i;

    // write ports
    always_comb
    begin
        wa_en   = 1'b0;
        wa_addr = ld_addr;
        wa_data = ld_data;
        wb_en   = 1'b0;
        wb_addr = k_reg[EAW-1:0];
        wb_data = w_data;
        if (ld_en)
        begin
            wa_en = 1'b1;
        end
        else if (state_reg == S_CMP)
        begin
            if (src_reg)
            begin
                wa_en   = 1'b1;
                wa_addr = k_reg[EAW-1:0];
                wa_data = w_data;
            end
            else
            begin
                wb_en = 1'b1;
            end
        end
    end

    // edge memories with registered reads
    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            mem_a[wa_addr] <= wa_data;
        end
        if (wb_en)
        begin
            mem_b[wb_addr] <= wb_data;
        end
        rd_a0 <= mem_a[addr0];
        rd_a1 <= mem_a[addr1];
        rd_b0 <= mem_b[addr0];
        rd_b1 <= mem_b[addr1];
    end

    assign sum_w  = lo_reg + width_reg;
    assign sum_2w = lo_reg + (width_reg << 1);

    // merge sequencer
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = XW'(cnt);
                    width_next = XW'(1);
                    src_next   = 1'b0;
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                if (width_reg >= cnt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_BLK;
                end
            end
            S_BLK:
            begin
                if (lo_reg >= cnt_reg)
                begin
                    width_next = width_reg << 1;
                    src_next   = ~src_reg;
                    state_next = S_PASS;
                end
                else
                begin
                    mid_next   = (sum_w > cnt_reg) ? cnt_reg : sum_w;
                    hi_next    = (sum_2w > cnt_reg) ? cnt_reg : sum_2w;
                    i_next     = lo_reg;
                    j_next     = (sum_w > cnt_reg) ? cnt_reg : sum_w;
                    k_next     = lo_reg;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (k_reg >= hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = S_BLK;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                k_next = k_reg + XW'(1);
                if (take_j)
                begin
                    j_next = j_reg + XW'(1);
                end
                else
                begin
                    i_next = i_reg + XW'(1);
                end
                state_next = S_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            done_reg  <= done_next;
        end
    end

    // pass counters
    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
    end

endmodule

FILE: hw/rtl/mstw_uf.sv
// union-find walk over the sorted edges: parent and rank memories, find with
// path compression, union by rank, weight accumulation; depends on mstw_pkg
module mstw_uf
    import mstw_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(MAX_NODES+1)-1:0]        n_eff,
    input  logic [$clog2(MAX_EDGES+1)-1:0]        cnt,
    output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
    input  edge_t                                 rd_data,
    output logic                                  done,
    output logic [SUM_W-1:0]                      sum,
    output logic [$clog2(MAX_NODES)-1:0]          taken
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES+1);
    localparam int NW  = $clog2(MAX_NODES+1);
    localparam int TW  = $clog2(MAX_NODES);
    localparam int RW  = $clog2(NW+1);

    localparam logic [3:0] U_IDLE = 4'd0;
    localparam logic [3:0] U_INIT = 4'd1;
    localparam logic [3:0] U_EREQ = 4'd2;
    localparam logic [3:0] U_EGET = 4'd3;
    localparam logic [3:0] U_FRD  = 4'd4;
    localparam logic [3:0] U_FCHK = 4'd5;
    localparam logic [3:0] U_CRD  = 4'd6;
    localparam logic [3:0] U_CCHK = 4'd7;
    localparam logic [3:0] U_JRA  = 4'd8;
    localparam logic [3:0] U_JRB  = 4'd9;
    localparam logic [3:0] U_JDO  = 4'd10;

    logic [NW-1:0] parent_mem [MAX_NODES+1];
    logic [RW-1:0] rank_mem   [MAX_NODES+1];

    logic [3:0]          state_reg, state_next;
    logic [NW:0]         vi_reg, vi_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       e_reg, e_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NW-1:0]       a_reg, a_next;
    logic [NW-1:0]       b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                side_reg, side_next;
    logic [NW-1:0]       root_reg, root_next;
    logic [NW-1:0]       ra_reg, ra_next;
    logic [RW-1:0]       rka_reg, rka_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [TW-1:0]       taken_reg, taken_next;
    logic                done_reg, done_next;

    logic          p_we, r_we;
    logic [NW-1:0] p_raddr, p_waddr, p_wdata, p_rdata;
    logic [NW-1:0] r_raddr, r_waddr;
    logic [RW-1:0] r_wdata, r_rdata;
    logic          bad_end;
    logic          tree_full;

    assign rd_addr = e_reg[EAW-1:0];
    assign done    = done_reg;
    assign sum     = sum_reg;
    assign taken   = taken_reg;

    // an end of zero or beyond the vertex count drops the edge
    assign bad_end = (rd_data.a == '0) || (rd_data.b == '0)
                  || (32'(rd_data.a) > 32'(n_reg)) || (32'(rd_data.b) > 32'(n_reg));

    // stop once the tree spans all vertices
    assign tree_full = ((NW+1)'(taken_reg) + (NW+1)'(1)) == ((NW+1)'(n_reg) - (NW+1)'(1));

    assign p_raddr = cur_reg;
    assign r_raddr = (state_reg == U_JRA) ? ra_reg : root_reg;

    // parent and rank memories with registered reads
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        if (r_we)
        begin
            rank_mem[r_waddr] <= r_wdata;
        end
        p_rdata <= parent_mem[p_raddr];
        r_rdata <= rank_mem[r_raddr];
    end

    // walk sequencer
    always_comb
    begin
        state_next = state_reg;
        vi_next    = vi_reg;
        cur_next   = cur_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        side_next  = side_reg;
        root_next  = root_reg;
        ra_next    = ra_reg;
        rka_next   = rka_reg;
        sum_next   = sum_reg;
        taken_next = taken_reg;
        done_next  = 1'b0;
        p_we       = 1'b0;
        p_waddr    = cur_reg;
        p_wdata    = root_reg;
        r_we       = 1'b0;
        r_waddr    = root_reg;
        r_wdata    = '0;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_eff;
                    cnt_next   = cnt;
                    vi_next    = (NW+1)'(1);
                    sum_next   = '0;
                    taken_next = '0;
                    state_next = U_INIT;
                end
            end
            U_INIT:
            begin
                if (vi_reg <= (NW+1)'(n_reg))
                begin
                    p_we    = 1'b1;
                    p_waddr = vi_reg[NW-1:0];
                    p_wdata = vi_reg[NW-1:0];
                    r_we    = 1'b1;
                    r_waddr = vi_reg[NW-1:0];
                    r_wdata = '0;
                    vi_next = vi_reg + (NW+1)'(1);
                end
                else if (n_reg < NW'(2))
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    e_next     = '0;
                    state_next = U_EREQ;
                end
            end
            U_EREQ:
            begin
                if (e_reg >= cnt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    state_next = U_EGET;
                end
            end
            U_EGET:
            begin
                if (bad_end)
                begin
                    e_next     = e_reg + CW'(1);
                    state_next = U_EREQ;
                end
                else
                begin
                    a_next     = NW'(rd_data.a);
                    b_next     = NW'(rd_data.b);
                    w_next     = rd_data.w;
                    cur_next   = NW'(rd_data.a);
                    side_next  = 1'b0;
                    state_next = U_FRD;
                end
            end
            U_FRD:
            begin
                state_next = U_FCHK;
            end
            U_FCHK:
            begin
                if (p_rdata == cur_reg)
                begin
                    root_next  = cur_reg;
                    cur_next   = side_reg ? b_reg : a_reg;
                    state_next = U_CRD;
                end
                else
                begin
                    cur_next   = p_rdata;
                    state_next = U_FRD;
                end
            end
            U_CRD:
            begin
                state_next = U_CCHK;
            end
            U_CCHK:
            begin
                if (p_rdata == root_reg)
                begin
                    if (!side_reg)
                    begin
                        ra_next    = root_reg;
                        side_next  = 1'b1;
                        cur_next   = b_reg;
                        state_next = U_FRD;
                    end
                    else if (ra_reg == root_reg)
                    begin
                        e_next     = e_reg + CW'(1);
                        state_next = U_EREQ;
                    end
                    else
                    begin
                        state_next = U_JRA;
                    end
                end
                else
                begin
                    // path compression: point this vertex at the root
                    p_we       = 1'b1;
                    cur_next   = p_rdata;
                    state_next = U_CRD;
                end
            end
            U_JRA:
            begin
                state_next = U_JRB;
            end
            U_JRB:
            begin
                rka_next   = r_rdata;
                state_next = U_JDO;
            end
            U_JDO:
            begin
                // union by rank, then count the edge
                p_we = 1'b1;
                if (rka_reg > r_rdata)
                begin
                    p_waddr = root_reg;
                    p_wdata = ra_reg;
                end
                else
                begin
                    p_waddr = ra_reg;
                    p_wdata = root_reg;
                    if (rka_reg == r_rdata)
                    begin
                        r_we    = 1'b1;
                        r_wdata = r_rdata + RW'(1);
                    end
                end
                sum_next   = sum_reg + SUM_W'($signed(w_reg));
                taken_next = taken_reg + TW'(1);
                if (tree_full)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    e_next     = e_reg + CW'(1);
                    state_next = U_EREQ;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
        end
    end

    // walk working registers
    always_ff @(posedge clk)
    begin
        vi_reg   <= vi_next;
        cur_reg  <= cur_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        w_reg    <= w_next;
        side_reg <= side_next;
        root_reg <= root_next;
        ra_reg   <= ra_next;
        rka_reg  <= rka_next;
    end

endmodule

FILE: dv/tb_minimum_spanning_tree_weight.sv
// testbench for the minimum spanning tree weight block: streams graphs of edges,
// predicts total weight, tree edge count and overflow; depends on mstw_pkg and the rtl
`timescale 1ns / 100ps

module tb_minimum_spanning_tree_weight;
    import mstw_pkg::*;

    // scoreboard: holds the edges of the open graph and the expected results
    class mst_scoreboard;
        edge_t     graph_edges[$];
        bit        graph_overflow;
        out_item_t pending_results[$];
        int        mismatches;
        int        results_seen;
        int        edges_seen;
        int        graphs_seen;
        logic [VERT_W-1:0] vertex_count;

        function int find_root(ref int parent[], input int v);
            int r;
            int nxt;
            r = v;
            while (parent[r] != r)
                r = parent[r];
            while (parent[v] != r)
            begin
                nxt = parent[v];
                parent[v] = r;
                v = nxt;
            end
            return r;
        endfunction

        // kruskal walk over the stored edges of one graph
        function out_item_t mst_of_graph();
            out_item_t res;
            edge_t     sorted[$];
            int        parent[];
            int        rnk[];
            int        n;
            int        ra;
            int        rb;
            longint    total;
            int        taken;
            n = vertex_count;
            if (n > MAX_NODES_DEF)
                n = MAX_NODES_DEF;
            // stable insertion sort by weight
            foreach (graph_edges[i])
            begin
                int k;
                k = sorted.size();
                while (k > 0 && sorted[k-1].w > graph_edges[i].w)
                    k--;
                sorted.insert(k, graph_edges[i]);
            end
            parent = new[n + 1];
            rnk = new[n + 1];
            for (int v = 0; v <= n; v++)
            begin
                parent[v] = v;
                rnk[v] = 0;
            end
            total = 0;
            taken = 0;
            if (n >= 2)
            begin
                foreach (sorted[i])
                begin
                    if (sorted[i].a == 0 || sorted[i].a > n || sorted[i].b == 0 ||
                        sorted[i].b > n)
                        continue;
                    ra = find_root(parent, sorted[i].a);
                    rb = find_root(parent, sorted[i].b);
                    if (ra == rb)
                        continue;
                    if (rnk[ra] > rnk[rb])
                        parent[rb] = ra;
                    else
                    begin
                        parent[ra] = rb;
                        if (rnk[ra] == rnk[rb])
                            rnk[rb]++;
                    end
                    total += longint'(sorted[i].w);
                    taken++;
                    if (taken == n - 1)
                        break;
                end
            end
            res.total_weight = total;
            res.tree_edges = taken[TREE_EDGES_W-1:0];
            res.overflow = graph_overflow;
            return res;
        endfunction

        function void note_edge(in_item_t beat);
            edge_t e;
            edges_seen++;
            if (graph_edges.size() < MAX_EDGES_DEF)
            begin
                e.a = beat.end_a;
                e.b = beat.end_b;
                e.w = beat.weight;
                graph_edges = {graph_edges, e};
            end
            else
                graph_overflow = 1'b1;
            if (beat.last_edge)
            begin
                pending_results = {pending_results, mst_of_graph()};
                graph_edges.delete();
                graph_overflow = 1'b0;
                graphs_seen++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result tw=%0d te=%0d ov=%0d", $time,
                         got.total_weight, got.tree_edges, got.overflow);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.total_weight !== exp.total_weight)
            begin
                $display("%0t: total_weight expected %0d actual %0d", $time,
                         exp.total_weight, got.total_weight);
                mismatches++;
            end
            if (got.tree_edges !== exp.tree_edges)
            begin
                $display("%0t: tree_edges expected %0d actual %0d", $time,
                         exp.tree_edges, got.tree_edges);
                mismatches++;
            end
            if (got.overflow !== exp.overflow)
            begin
                $display("%0t: overflow expected %0d actual %0d", $time,
                         exp.overflow, got.overflow);
                mismatches++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [VERT_W-1:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    mst_scoreboard sb;
    bit        quiet_tail;
    bit        hold_receiver;
    int        idle_cycles;

    minimum_spanning_tree_weight DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // sender: one edge beat, with an optional random gap first; valid stays
    // high after the beat so that back to back beats need no second assignment
    task automatic send_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                             input logic [31:0] w, input bit last);
        in_item_t beat;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        beat.end_a = a;
        beat.end_b = b;
        beat.weight = w;
        beat.last_edge = last;
        in_valid <= 1'b1;
        in_item <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_edge(beat);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if (hold_receiver)
                out_ready <= 1'b0;
            else if (idle_cycles > 0)
            begin
                idle_cycles <= idle_cycles - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                idle_cycles <= $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    int stall_count;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stop offering, wait until every expected result has come, then settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [VERT_W-1:0] n);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= n;
        sb.vertex_count = n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // one random graph; mostly in-range vertices, a few out of range
    task automatic send_graph(input int n_edges, input int n_nodes);
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        for (int i = 0; i < n_edges; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                a = VERT_W'($urandom);
                b = VERT_W'($urandom);
            end
            else
            begin
                a = VERT_W'($urandom_range(1, n_nodes < 1 ? 1 : n_nodes));
                b = VERT_W'($urandom_range(1, n_nodes < 1 ? 1 : n_nodes));
            end
            send_edge(a, b, rand_weight(), i == n_edges - 1);
        end
    endtask

    int sent;
    int nn;
    initial
    begin
        sb = new();
        sb.vertex_count = 1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        quiet_tail = 1'b0;
        hold_receiver = 1'b0;
        idle_cycles = 0;
        stall_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset node count of one: nothing taken
        send_edge(1, 2, 5, 1'b1);
        write_node_count(4);
        // self loop, vertex zero, out of range, equal weights, extremes
        send_edge(1, 1, 32'h8000_0000, 1'b0);
        send_edge(0, 2, 1, 1'b0);
        send_edge(3, 11'h7FF, 1, 1'b0);
        send_edge(1, 2, 32'h7FFF_FFFF, 1'b0);
        send_edge(2, 3, 7, 1'b0);
        send_edge(3, 4, 7, 1'b0);
        send_edge(1, 4, 7, 1'b1);
        write_node_count(0);
        send_edge(1, 2, 3, 1'b1);
        write_node_count(1024);
        send_edge(1024, 1, 32'h8000_0000, 1'b0);
        send_edge(11'h400, 11'h3FF, 32'hFFFF_FFFF, 1'b0);
        send_edge(11'h7FF, 11'h7FF, 0, 1'b1);
        write_node_count(11'h7FF);
        send_edge(1024, 1023, 32'h5555_5555, 1'b0);
        send_edge(11'h2AA, 11'h555, 32'hAAAA_AAAA, 1'b1);

        // receiver held off while the sender keeps going
        write_node_count(6);
        hold_receiver = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_receiver = 1'b0;
            end
            begin
                for (int g = 0; g < 6; g++)
                    send_graph(4, 6);
            end
        join
        sent = 40;

        // random graphs over several vertex counts
        while (sent < 1150)
        begin
            case ($urandom_range(0, 5))
                0: nn = 2;
                1: nn = $urandom_range(3, 8);
                2: nn = $urandom_range(9, 40);
                3: nn = 1024;
                4: nn = $urandom_range(0, 2047);
                default: nn = $urandom_range(3, 16);
            endcase
            write_node_count(VERT_W'(nn));
            for (int g = 0; g < 4; g++)
            begin
                int ne;
                ne = $urandom_range(1, 12);
                if (sent > 1000)
                    quiet_tail = 1'b1;
                send_graph(ne, nn > 1024 ? 1024 : nn);
                sent += ne;
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d edges in %0d graphs, %0d results checked",
                 sb.edges_seen, sb.graphs_seen, sb.results_seen);
        $display("vertex counts 0 to 2047, extreme weights, self loops, bad vertices");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
